>>> rtl/tmwf_pkg.sv
package tmwf_pkg;

  // Sample and result width
  localparam int SAMPLE_W = 16;

  // Default window length (new sample plus stored samples)
  localparam int WINDOW_DEF = 10;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_DIV
  } state_t;

endpackage

>>> rtl/trimmed_mean_window_filter.sv
// Trimmed-mean moving-average filter. Each input word is a signed 16-bit
// sample; the window is that sample plus the WINDOW-1 samples before it,
// held in a row of cells that reset clears to zero, so early results see
// zeros. One largest and one smallest value are dropped, the rest summed
// and divided by WINDOW-2, truncating toward zero; one result word leaves
// per sample. One sample is in flight at a time: the next is accepted
// only after the current result is loaded into the output register. A
// token walks the cell row one cell per cycle to collect sum, maximum
// and minimum, a register drops the extremes, and a multiply by the
// constant reciprocal of WINDOW-2 yields the quotient from a registered
// magnitude and product. The result word sits in an output register
// until taken; while a word waits there, the next result and so the next
// accept stall.
module trimmed_mean_window_filter #(
  parameter int WINDOW = tmwf_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] mean_out
);

  localparam int SW     = tmwf_pkg::SAMPLE_W;
  localparam int DEPTH  = WINDOW - 1;
  localparam int SUM_W  = SW + $clog2(WINDOW);

  tmwf_pkg::state_t state, state_next;

  logic                 accept;
  logic                 seed_valid;
  logic signed [SUM_W-1:0] seed_sum;
  logic signed [SW-1:0]    seed_ext;

  logic signed [SW-1:0]    data_chain [0:DEPTH];
  logic                    tok_valid  [0:DEPTH];
  logic signed [SUM_W-1:0] tok_sum    [0:DEPTH];
  logic signed [SW-1:0]    tok_hi     [0:DEPTH];
  logic signed [SW-1:0]    tok_lo     [0:DEPTH];

  logic signed [SUM_W-1:0] trim_sum;
  logic                    div_start;
  logic                    div_ack;
  logic                    div_done;
  logic signed [SW-1:0]    div_quo;
  logic                    load_out;
  logic [SW-1:0]           out_data;
  logic                    out_valid;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Seed the token with the oldest sample, which the shift pushes out
  assign seed_ext = data_chain[DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_valid <= 1'b0;
    end else begin
      seed_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seed_sum <= {{(SUM_W - SW){seed_ext[SW-1]}}, seed_ext};
    end
  end

  assign data_chain[0] = s_axis_tdata;
  assign tok_valid[0]  = seed_valid;
  assign tok_sum[0]    = seed_sum;
  assign tok_hi[0]     = seed_sum[SW-1:0];
  assign tok_lo[0]     = seed_sum[SW-1:0];

  // Row of history cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    tmwf_cell #(
      .SUM_W(SUM_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .shift_en     (accept),
      .data_in      (data_chain[k]),
      .data_out     (data_chain[k+1]),
      .tok_valid_in (tok_valid[k]),
      .sum_in       (tok_sum[k]),
      .hi_in        (tok_hi[k]),
      .lo_in        (tok_lo[k]),
      .tok_valid_out(tok_valid[k+1]),
      .sum_out      (tok_sum[k+1]),
      .hi_out       (tok_hi[k+1]),
      .lo_out       (tok_lo[k+1])
    );
  end

  // Drop one maximum and one minimum from the collected sum
  always_ff @(posedge clk) begin
    if ((state == tmwf_pkg::ST_SCAN) && tok_valid[DEPTH]) begin
      trim_sum <= tok_sum[DEPTH]
                - {{(SUM_W - SW){tok_hi[DEPTH][SW-1]}}, tok_hi[DEPTH]}
                - {{(SUM_W - SW){tok_lo[DEPTH][SW-1]}}, tok_lo[DEPTH]};
    end
  end

  tmwf_div #(
    .SUM_W  (SUM_W),
    .DIVISOR(WINDOW - 2)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .ack     (div_ack),
    .dividend(trim_sum),
    .done    (div_done),
    .quotient(div_quo)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tmwf_pkg::ST_IDLE: if (accept) state_next = tmwf_pkg::ST_SCAN;
      tmwf_pkg::ST_SCAN: if (tok_valid[DEPTH]) state_next = tmwf_pkg::ST_TRIM;
      tmwf_pkg::ST_TRIM: state_next = tmwf_pkg::ST_DIV;
      tmwf_pkg::ST_DIV:  if (load_out) state_next = tmwf_pkg::ST_IDLE;
      default:           state_next = tmwf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      tmwf_pkg::ST_IDLE: s_axis_tready = 1'b1;
      tmwf_pkg::ST_SCAN: ;
      tmwf_pkg::ST_TRIM: div_start = 1'b1;
      tmwf_pkg::ST_DIV:  load_out = div_done && (!out_valid || m_axis_tready);
      default:           ;
    endcase
  end

  assign div_ack = load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmwf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= div_quo;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

>>> rtl/tmwf_cell.sv
module tmwf_cell #(
  parameter int SUM_W = 20
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  shift_en,
  input  logic signed [tmwf_pkg::SAMPLE_W-1:0]  data_in,
  output logic signed [tmwf_pkg::SAMPLE_W-1:0]  data_out,
  input  logic                                  tok_valid_in,
  input  logic signed [SUM_W-1:0]               sum_in,
  input  logic signed [tmwf_pkg::SAMPLE_W-1:0]  hi_in,
  input  logic signed [tmwf_pkg::SAMPLE_W-1:0]  lo_in,
  output logic                                  tok_valid_out,
  output logic signed [SUM_W-1:0]               sum_out,
  output logic signed [tmwf_pkg::SAMPLE_W-1:0]  hi_out,
  output logic signed [tmwf_pkg::SAMPLE_W-1:0]  lo_out
);

  logic signed [tmwf_pkg::SAMPLE_W-1:0] value;
  logic signed [SUM_W-1:0]              value_ext;

  assign data_out  = value;
  assign value_ext = {{(SUM_W - tmwf_pkg::SAMPLE_W){value[tmwf_pkg::SAMPLE_W-1]}}, value};

  // Hold one history sample; advance it to the neighbor on a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift_en) begin
      value <= data_in;
    end
  end

  // Pass the running token along, folding in this cell's sample
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid_out <= 1'b0;
    end else begin
      tok_valid_out <= tok_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid_in) begin
      sum_out <= sum_in + value_ext;
      hi_out  <= (value > hi_in) ? value : hi_in;
      lo_out  <= (value < lo_in) ? value : lo_in;
    end
  end

endmodule

>>> rtl/tmwf_div.sv
module tmwf_div #(
  parameter int SUM_W   = 20,
  parameter int DIVISOR = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 ack,
  input  logic signed [SUM_W-1:0]              dividend,
  output logic                                 done,
  output logic signed [tmwf_pkg::SAMPLE_W-1:0] quotient
);

  // Magnitude of a trimmed sum fits one bit below the signed sum width
  localparam int MAG_W  = SUM_W - 1;
  // Scale the reciprocal so the truncated product is the exact quotient
  // for every magnitude below 2**MAG_W
  localparam int SH     = MAG_W + $clog2(DIVISOR);
  localparam int RCP_W  = SH + 1;
  localparam int FULL_W = MAG_W + RCP_W;
  localparam longint RCP_L = ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1))
                             / longint'(DIVISOR);
  localparam logic [RCP_W-1:0] RCP_K = RCP_W'(RCP_L);

  logic              mul_pend;
  logic              held;
  logic [MAG_W-1:0]  mag;
  logic              neg;
  logic [FULL_W-1:0] prod;

  logic [SUM_W-1:0]  abs_in;
  logic [FULL_W-1:0] full_prod;
  logic [MAG_W-1:0]  quo;
  logic [MAG_W-1:0]  signed_quo;

  assign abs_in = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;

  // Advance start -> multiply -> hold until the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pend <= 1'b0;
      held     <= 1'b0;
    end else if (start) begin
      mul_pend <= 1'b1;
      held     <= 1'b0;
    end else if (mul_pend) begin
      mul_pend <= 1'b0;
      held     <= 1'b1;
    end else if (ack) begin
      held     <= 1'b0;
    end
  end

  // Capture magnitude and sign of the trimmed sum
  always_ff @(posedge clk) begin
    if (start) begin
      mag <= abs_in[MAG_W-1:0];
      neg <= dividend[SUM_W-1];
    end
  end

  // Multiply by the constant reciprocal
  assign full_prod = FULL_W'(mag) * FULL_W'(RCP_K);

  always_ff @(posedge clk) begin
    if (mul_pend) begin
      prod <= full_prod;
    end
  end

  // Restore the sign; quotient truncates toward zero
  assign quo        = prod[SH +: MAG_W];
  assign signed_quo = neg ? (MAG_W'(0) - quo) : quo;
  assign quotient   = signed_quo[tmwf_pkg::SAMPLE_W-1:0];
  assign done       = held;

endmodule
